/* rtl/rpn_pkg.sv */
// Shared types and codes for the RPN stack evaluator.
package rpn_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        MODE_PUSH = 3'd0,
        MODE_ADD  = 3'd1,
        MODE_SUB  = 3'd2,
        MODE_MUL  = 3'd3,
        MODE_DIV  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2,
        ERR_DIVZERO   = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef enum logic [1:0] {
        AL_IDLE,
        AL_DIV,
        AL_FIX
    } alu_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_WAIT,
        ST_REPORT
    } ctrl_state_t;

endpackage

/* rtl/rpn_stack_evaluator.sv */
// Top level: token sequencer, stack control and result register.
// A token is taken in idle, then passes through read, exec, a wait on the arithmetic unit
// for an add, sub, mult or div that can run, and report; the next token is accepted only
// after the result is loaded, so one token is in flight at a time and report stalls while the output is full.
// Divide takes longest: the shared unit retires one quotient bit a cycle.
// rst_n (asynchronous, active low) empties the stack and clears the error;
// stack words are not cleared and need no clearing pass.
module rpn_stack_evaluator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    localparam int DW         = $clog2(STACK_DEPTH + 1),
    localparam int OUT_W      = ((WORD_W + DW + 2 + 7) / 8) * 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [WORD_W-1:0] s_tdata,   // operand_value
    input  logic [2:0]        s_tuser,   // mode
    input  logic              s_tlast,   // last_token
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // top_value, stack_depth, error_code, zero fill
    output logic              m_tlast    // final_result
);

    localparam int AW = $clog2(STACK_DEPTH);

    ctrl_state_t       state_reg, state_next;
    logic [2:0]        mode_reg;
    logic [WORD_W-1:0] value_reg;
    logic              last_reg;
    logic [DW-1:0]     depth_reg;
    err_t              err_reg;
    logic [WORD_W-1:0] top_reg;
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic              out_last_reg;

    logic              active;
    logic              is_op;
    logic              full;
    logic              few;
    logic              div_zero;
    logic              op_go;
    logic              out_free;
    logic [DW-1:0]     depth_m2;
    alu_req_t          alu_req;
    logic              alu_done;
    logic [WORD_W-1:0] alu_result;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata;
    logic [OUT_W-1:0]  out_data;
    err_t              err_out;

    assign active   = (err_reg == ERR_NONE);
    assign is_op    = (mode_reg == MODE_ADD) || (mode_reg == MODE_SUB) ||
                      (mode_reg == MODE_MUL) || (mode_reg == MODE_DIV);
    assign full     = (depth_reg >= DW'(STACK_DEPTH));
    assign few      = (depth_reg < DW'(2));
    assign div_zero = (mode_reg == MODE_DIV) && (top_reg == '0);
    assign op_go    = active && is_op && !few && !div_zero;
    assign out_free = !m_tvalid_reg || m_tready;
    assign depth_m2 = depth_reg - DW'(2);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = op_go ? ST_WAIT : ST_REPORT;
            end
            ST_WAIT:
            begin
                if (alu_done)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        alu_req.start = 1'b0;
        alu_req.op    = ALU_ADD;
        mem_we        = 1'b0;
        mem_waddr     = depth_reg[AW-1:0];
        mem_wdata     = value_reg;
        case (mode_reg)
            MODE_SUB: alu_req.op = ALU_SUB;
            MODE_MUL: alu_req.op = ALU_MUL;
            MODE_DIV: alu_req.op = ALU_DIV;
            default:  alu_req.op = ALU_ADD;
        endcase
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_EXEC:
            begin
                alu_req.start = op_go;
                mem_we        = active && (mode_reg == MODE_PUSH) && !full;
            end
            ST_WAIT:
            begin
                mem_we    = alu_done;
                mem_waddr = depth_m2[AW-1:0];
                mem_wdata = alu_result;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (last_reg && active && depth_reg == '0)
        begin
            err_out = ERR_UNDERFLOW;
        end
        else
        begin
            err_out = err_reg;
        end
        out_data                = '0;
        out_data[WORD_W-1:0]    = (depth_reg != '0) ? top_reg : '0;
        out_data[WORD_W +: DW]  = depth_reg;
        out_data[WORD_W+DW +: 2] = err_out;
    end

    rpn_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (depth_m2[AW-1:0]),
        .rdata (mem_rdata)
    );

    rpn_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (mem_rdata),
        .b      (top_reg),
        .done   (alu_done),
        .result (alu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            depth_reg    <= '0;
            err_reg      <= ERR_NONE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EXEC && active)
            begin
                if (mode_reg == MODE_PUSH)
                begin
                    if (full)
                    begin
                        err_reg <= ERR_OVERFLOW;
                    end
                    else
                    begin
                        depth_reg <= depth_reg + 1'b1;
                    end
                end
                else if (is_op && few)
                begin
                    err_reg <= ERR_UNDERFLOW;
                end
                else if (is_op && div_zero)
                begin
                    err_reg <= ERR_DIVZERO;
                end
            end
            if (state_reg == ST_WAIT && alu_done)
            begin
                depth_reg <= depth_reg - 1'b1;
            end
            if (state_reg == ST_REPORT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
                // end of expression: empty the stack and drop the error
                if (last_reg)
                begin
                    depth_reg <= '0;
                    err_reg   <= ERR_NONE;
                end
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            mode_reg  <= s_tuser;
            value_reg <= s_tdata;
            last_reg  <= s_tlast;
        end
        if (state_reg == ST_EXEC && active && mode_reg == MODE_PUSH && !full)
        begin
            top_reg <= value_reg;
        end
        if (state_reg == ST_WAIT && alu_done)
        begin
            top_reg <= alu_result;
        end
        if (state_reg == ST_REPORT && out_free)
        begin
            out_data_reg <= out_data;
            out_last_reg <= last_reg && active && (depth_reg != '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_alu_start_legal: assert property (@(posedge clk) disable iff (!rst_n)
        alu_req.start |-> (err_reg == ERR_NONE && depth_reg >= DW'(2)))
        else $error("arithmetic started without two operands or with an error set");

    a_alu_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> state_reg == ST_WAIT)
        else $error("arithmetic result arrived outside the wait state");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPORT && out_free && last_reg)
            |=> (depth_reg == '0 && err_reg == ERR_NONE))
        else $error("stack not cleared after the last token");

endmodule

/* rtl/rpn_mem.sv */
// Stack storage: one write port, one registered read port.
module rpn_mem
    import rpn_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rpn_alu.sv */
// Shared arithmetic unit: registered add, sub and mult, bit-serial signed divide.
module rpn_alu
    import rpn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  alu_req_t          req,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output logic              done,
    output logic [WORD_W-1:0] result
);

    localparam int CNT_W = $clog2(WORD_W);

    alu_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] quot_reg;
    logic [WORD_W-1:0] divisor_reg;
    logic              neg_reg;
    logic [WORD_W-1:0] result_reg;
    logic              done_reg;
    logic              done_next;

    logic              div_step;
    logic              div_fix;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   trial;
    logic [WORD_W-1:0] mag_a;
    logic [WORD_W-1:0] mag_b;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            AL_IDLE:
            begin
                if (req.start && req.op == ALU_DIV)
                begin
                    state_next = AL_DIV;
                end
            end
            AL_DIV:
            begin
                if (count_reg == '0)
                begin
                    state_next = AL_FIX;
                end
            end
            AL_FIX:
            begin
                state_next = AL_IDLE;
            end
            default:
            begin
                state_next = AL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        div_step  = 1'b0;
        div_fix   = 1'b0;
        done_next = 1'b0;
        case (state_reg)
            AL_IDLE:
            begin
                done_next = req.start && req.op != ALU_DIV;
            end
            AL_DIV:
            begin
                div_step = 1'b1;
            end
            AL_FIX:
            begin
                div_fix   = 1'b1;
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // divide on magnitudes, fix the sign afterwards
    assign mag_a   = a[WORD_W-1] ? (~a + 1'b1) : a;
    assign mag_b   = b[WORD_W-1] ? (~b + 1'b1) : b;
    assign shifted = {rem_reg, quot_reg[WORD_W-1]};
    assign trial   = shifted - {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AL_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == AL_IDLE && req.start)
        begin
            case (req.op)
                ALU_ADD:
                begin
                    result_reg <= a + b;
                end
                ALU_SUB:
                begin
                    result_reg <= a - b;
                end
                ALU_MUL:
                begin
                    result_reg <= a * b;
                end
                ALU_DIV:
                begin
                    quot_reg    <= mag_a;
                    divisor_reg <= mag_b;
                    rem_reg     <= '0;
                    neg_reg     <= a[WORD_W-1] ^ b[WORD_W-1];
                    count_reg   <= CNT_W'(WORD_W - 1);
                end
                default:
                begin
                    result_reg <= a + b;
                end
            endcase
        end
        if (div_step)
        begin
            // shift one dividend bit in, keep the difference when it fits
            if (!trial[WORD_W])
            begin
                rem_reg  <= trial[WORD_W-1:0];
                quot_reg <= {quot_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted[WORD_W-1:0];
                quot_reg <= {quot_reg[WORD_W-2:0], 1'b0};
            end
            count_reg <= count_reg - 1'b1;
        end
        if (div_fix)
        begin
            result_reg <= neg_reg ? (~quot_reg + 1'b1) : quot_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* bench/tb_rpn_stack_evaluator.sv */
`timescale 1ns / 100ps
// Testbench for the RPN stack evaluator: scripted and random token streams, self-checked.
module tb_rpn_stack_evaluator
    import rpn_pkg::*;
();

    localparam int STACK_MAX    = 16;
    localparam int STACK_AW     = $clog2(STACK_MAX);
    localparam int DEPTH_W      = $clog2(STACK_MAX + 1);
    localparam int RES_W        = ((WORD_W + DEPTH_W + 2 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 60;
    localparam int REPORT_CAP   = 40;
    localparam int MAX_GAP      = 20;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [2:0] MODE_UNUSED_LO  = 3'd5;
    localparam logic [2:0] MODE_UNUSED_MID = 3'd6;
    localparam logic [2:0] MODE_UNUSED_HI  = 3'd7;

    typedef struct {
        logic [WORD_W-1:0]  top;
        logic [DEPTH_W-1:0] depth;
        err_t               err;
        logic               fin;
    } eval_result_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [WORD_W-1:0] s_tdata  = '0;     // operand_value
    logic [2:0]        s_tuser  = '0;     // mode
    logic              s_tlast  = 1'b0;   // last_token
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [RES_W-1:0]  m_tdata;           // top_value, stack_depth, error_code, zero fill
    logic              m_tlast;           // final_result

    // evaluator state mirrored from the block
    logic [WORD_W-1:0] model_stack [STACK_MAX];
    int unsigned       model_depth = 0;
    err_t              model_err   = ERR_NONE;

    eval_result_t      pending_results[$];
    int unsigned       send_gap_pct = 0;
    int unsigned       recv_gap_pct = 0;
    int unsigned       hold_request = 0;
    int unsigned       hold_left    = 0;
    int unsigned       tokens_sent  = 0;
    int unsigned       fail_count   = 0;
    int unsigned       cycle_count  = 0;

    rpn_stack_evaluator #(.STACK_DEPTH(STACK_MAX)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    function automatic eval_result_t evaluate_token(input logic [2:0] code,
                                                    input logic [WORD_W-1:0] value,
                                                    input logic last);
        eval_result_t      res;
        logic [WORD_W-1:0] lhs;
        logic [WORD_W-1:0] rhs;
        logic [WORD_W-1:0] acc;
        longint            quot;
        bit                write_back;
        write_back = 1'b0;
        acc = '0;
        if (model_err == ERR_NONE)
        begin
            case (code)
                MODE_PUSH:
                begin
                    if (model_depth >= STACK_MAX)
                        model_err = ERR_OVERFLOW;
                    else
                    begin
                        model_stack[STACK_AW'(model_depth)] = value;
                        model_depth++;
                    end
                end
                MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV:
                begin
                    if (model_depth < 2)
                        model_err = ERR_UNDERFLOW;
                    else
                    begin
                        rhs = model_stack[STACK_AW'(model_depth - 1)];
                        lhs = model_stack[STACK_AW'(model_depth - 2)];
                        write_back = 1'b1;
                        case (code)
                            MODE_ADD: acc = lhs + rhs;
                            MODE_SUB: acc = lhs - rhs;
                            MODE_MUL: acc = lhs * rhs;
                            default:
                            begin
                                if (rhs == '0)
                                begin
                                    model_err = ERR_DIVZERO;
                                    write_back = 1'b0;
                                end
                                else
                                begin
                                    // widen so the most negative over minus one wraps back
                                    quot = longint'($signed(lhs)) / longint'($signed(rhs));
                                    acc = quot[WORD_W-1:0];
                                end
                            end
                        endcase
                        if (write_back)
                        begin
                            model_depth--;
                            model_stack[STACK_AW'(model_depth - 1)] = acc;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (last && model_err == ERR_NONE && model_depth == 0)
            model_err = ERR_UNDERFLOW;
        res.top   = (model_depth > 0) ? model_stack[STACK_AW'(model_depth - 1)] : '0;
        res.depth = model_depth[DEPTH_W-1:0];
        res.err   = model_err;
        res.fin   = last && (model_err == ERR_NONE);
        if (last)
        begin
            model_depth = 0;
            model_err = ERR_NONE;
        end
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5: return $urandom_range(20) - 10;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_token(input logic [2:0] code, input logic [WORD_W-1:0] value,
                              input logic last);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_gap_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= code;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(evaluate_token(code, value, last));
        tokens_sent++;
    endtask

    task automatic send_expression();
        int unsigned style;
        int unsigned len;
        int unsigned deep_pushes;
        logic [2:0]  code;
        style = $urandom_range(99);
        len = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 12);
        deep_pushes = $urandom_range(14, 18);
        if (style >= 90)
            len = deep_pushes + $urandom_range(1, 6);
        for (int unsigned i = 0; i < len; i++)
        begin
            if (style < 10)
                code = 3'($urandom_range(MODE_UNUSED_HI));
            else if (style >= 90)
                code = (i < deep_pushes) ? MODE_PUSH : 3'($urandom_range(MODE_ADD, MODE_DIV));
            else if ($urandom_range(49) == 0)
                code = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            else if (model_depth < 2)
                code = MODE_PUSH;
            else if (model_depth >= STACK_MAX || $urandom_range(1) == 0)
                code = 3'($urandom_range(MODE_ADD, MODE_DIV));
            else
                code = MODE_PUSH;
            // noise expressions may also end early
            send_token(code, pick_value(),
                       (i == len - 1) || (style < 10 && $urandom_range(7) == 0));
        end
    endtask

    task automatic test_directed();
        // wrap, most negative over minus one, truncation, unused codes
        send_token(MODE_PUSH, 32'h7FFF_FFFF, 1'b0);
        send_token(MODE_PUSH, 32'h0000_0001, 1'b0);
        send_token(MODE_ADD, 32'h0, 1'b0);
        send_token(MODE_PUSH, 32'hFFFF_FFFF, 1'b0);
        send_token(MODE_DIV, 32'h0, 1'b0);
        send_token(MODE_PUSH, 32'd3, 1'b0);
        send_token(MODE_MUL, 32'h0, 1'b0);
        send_token(MODE_PUSH, 32'd5, 1'b0);
        send_token(MODE_SUB, 32'h0, 1'b0);
        send_token(MODE_PUSH, 32'hFFFF_FFF9, 1'b0);
        send_token(MODE_PUSH, 32'd2, 1'b0);
        send_token(MODE_UNUSED_LO, 32'hFFFF_FFFF, 1'b0);
        send_token(MODE_DIV, 32'h0, 1'b0);
        send_token(MODE_UNUSED_HI, 32'h0, 1'b1);
        // divide by zero, then tokens ignored while the error holds
        send_token(MODE_PUSH, 32'd9, 1'b0);
        send_token(MODE_PUSH, 32'd0, 1'b0);
        send_token(MODE_DIV, 32'h0, 1'b0);
        send_token(MODE_PUSH, 32'd1, 1'b0);
        send_token(MODE_ADD, 32'h0, 1'b1);
        // operator on an empty stack, last token on an empty stack
        send_token(MODE_ADD, 32'h0, 1'b1);
        send_token(MODE_UNUSED_MID, 32'h0, 1'b1);
        send_token(MODE_PUSH, 32'hA5A5_A5A5, 1'b1);
    endtask

    task automatic test_stack_limits();
        for (int i = 0; i < STACK_MAX; i++)
            send_token(MODE_PUSH, $urandom, 1'b0);
        send_token(MODE_PUSH, 32'h1234_5678, 1'b0);
        send_token(MODE_SUB, 32'h0, 1'b1);
    endtask

    task automatic test_random(input int unsigned count, input int unsigned send_pct,
                               input int unsigned recv_pct);
        int unsigned first;
        first = tokens_sent;
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
        while (tokens_sent - first < count)
            send_expression();
    endtask

    task automatic test_backpressure();
        send_gap_pct = 0;
        recv_gap_pct = 0;
        hold_request = HOLD_CYCLES;
        // keep offering while results back up
        for (int i = 0; i < 6; i++)
            send_token(MODE_PUSH, $urandom, 1'b0);
        send_token(MODE_MUL, 32'h0, 1'b0);
        send_token(MODE_DIV, 32'h0, 1'b0);
        send_token(MODE_ADD, 32'h0, 1'b1);
    endtask

    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_gap_pct);
    end

    always @(posedge clk)
    begin
        eval_result_t want;
        logic [DEPTH_W-1:0] got_depth;
        logic [1:0]         got_err;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_depth = m_tdata[WORD_W +: DEPTH_W];
            got_err   = m_tdata[WORD_W + DEPTH_W +: 2];
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                    $display("%0t: unexpected transaction, actual data %h last %b",
                             $time, m_tdata, m_tlast);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[WORD_W-1:0] !== want.top || got_depth !== want.depth
                    || got_err !== want.err || m_tlast !== want.fin)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $display({"%0t: mismatch, expected top %h depth %0d err %0d fin %b,",
                                  " actual top %h depth %0d err %0d fin %b"},
                                 $time, want.top, want.depth, want.err, want.fin,
                                 m_tdata[WORD_W-1:0], got_depth, got_err, m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_gap_pct = 10;
        recv_gap_pct = 57;
        test_directed();
        test_stack_limits();
        test_random(650, 10, 57);
        test_random(650, 57, 10);
        test_backpressure();
        test_random(600, 0, 0);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/rpn_pkg.sv
rtl/rpn_mem.sv
rtl/rpn_alu.sv
rtl/rpn_stack_evaluator.sv
bench/tb_rpn_stack_evaluator.sv
